[src/hpr_pkg.sv]
`default_nettype none
package hpr_pkg;
   localparam int THREADS = 8;
   localparam int SLOTS_PER_THREAD = 4;
   localparam int RETIRE_DEPTH = 32;
   localparam int ADDR_BITS = 48;
   localparam int NSLOTS = THREADS * SLOTS_PER_THREAD;
   localparam int TID_W = 3;
   localparam int SLOT_W = 2;
   localparam int RD_W = $clog2(RETIRE_DEPTH);
   localparam int CNT_W = $clog2(RETIRE_DEPTH + 1);
   localparam int MEM_W = $clog2(THREADS * RETIRE_DEPTH);
   localparam int HS_W = $clog2(NSLOTS);

   typedef enum logic [1:0] {
      KIND_RESERVE   = 2'd0,
      KIND_CLEAR_ONE = 2'd1,
      KIND_CLEAR_ALL = 2'd2,
      KIND_RETIRE    = 2'd3
   } kind_type;

   localparam logic [1:0] REG_COLLECT_ENABLE = 2'd0;
   localparam logic [1:0] REG_SCAN_FREQUENCY = 2'd1;

   // controller to datapath
   typedef struct packed {
      logic capture;    // latch request
      logic table_op;   // apply reserve or clear
      logic retire_wr;  // append retired pointer
      logic scan_init;  // start walk of list
      logic scan_rd;    // issue memory read at read index
      logic scan_eval;  // evaluate fetched entry
      logic scan_done;  // commit surviving count
      logic emit_ovf;   // load overflow result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_retire;
      logic is_null;
      logic list_full;
      logic want_scan;
      logic scan_empty;   // nothing left to read
      logic entry_free;   // evaluated entry is unprotected
      logic out_busy;     // output register holds a result not taken
      logic any_freed;    // a freed result is held back
   } stat_type;
endpackage
`default_nettype wire

[src/hpr_if.sv]
`default_nettype none
interface hpr_req_if;
   logic valid;
   logic ready;
   logic [1:0] kind;
   logic [2:0] thread_id;
   logic [1:0] slot_index;
   logic [47:0] pointer_value;
   modport source (output valid, kind, thread_id, slot_index, pointer_value, input ready);
   modport sink (input valid, kind, thread_id, slot_index, pointer_value, output ready);
endinterface

interface hpr_rsp_if;
   logic valid;
   logic ready;
   logic [47:0] freed_pointer;
   logic [2:0] owner_thread;
   logic overflow;
   logic last_of_run;
   modport source (output valid, freed_pointer, owner_thread, overflow, last_of_run,
                   input ready);
   modport sink (input valid, freed_pointer, owner_thread, overflow, last_of_run,
                 output ready);
endinterface
`default_nettype wire

[src/hpr_datapath.sv]
`default_nettype none
module hpr_datapath (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic [1:0] req_kind,
   input  wire logic [2:0] req_thread_id,
   input  wire logic [1:0] req_slot_index,
   input  wire logic [47:0] req_pointer_value,
   input  wire logic collect_enable,
   input  wire logic [7:0] scan_frequency,
   input  wire hpr_pkg::cmd_type cmd,
   output hpr_pkg::stat_type stat,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic [47:0] rsp_freed_pointer,
   output logic [2:0] rsp_owner_thread,
   output logic rsp_overflow,
   output logic rsp_last_of_run
);
   import hpr_pkg::*;

   logic [ADDR_BITS-1:0] hazard_ff [NSLOTS];
   logic [ADDR_BITS-1:0] retired_mem [THREADS*RETIRE_DEPTH];
   logic [CNT_W-1:0] count_ff [THREADS];
   logic [7:0] rcnt_ff [THREADS];

   logic [1:0] kind_ff;
   logic [TID_W-1:0] tid_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [ADDR_BITS-1:0] ptr_ff;
   logic [CNT_W-1:0] rd_ff, rd_in, wr_ff, wr_in, n_ff;
   logic [ADDR_BITS-1:0] rdata_ff;
   logic prot;
   logic rsp_valid_ff;
   logic [47:0] out_ptr_ff;
   logic out_ovf_ff, out_last_ff;
   logic [TID_W-1:0] out_tid_ff;
   logic [MEM_W-1:0] wr_addr;
   logic held_ff;
   logic [ADDR_BITS-1:0] held_ptr_ff;
   logic take_free;
   logic push_held;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_kind;
         tid_ff  <= req_thread_id;
         slot_ff <= req_slot_index;
         ptr_ff  <= req_pointer_value[ADDR_BITS-1:0];
      end
   end

   // hazard table compare, one slot each, independent
   always_comb begin
      prot = 1'b0;
      for (int i = 0; i < NSLOTS; i++) begin
         if (hazard_ff[i] == rdata_ff) prot = 1'b1;
      end
   end

   // status toward the controller
   always_comb begin
      stat.is_retire  = (kind_ff == KIND_RETIRE);
      stat.is_null    = (ptr_ff == '0);
      stat.list_full  = (count_ff[tid_ff] >= CNT_W'(RETIRE_DEPTH));
      stat.want_scan  = collect_enable && (rcnt_ff[tid_ff] == scan_frequency);
      stat.scan_empty = (rd_ff >= n_ff);
      stat.entry_free = !prot;
      stat.out_busy   = rsp_valid_ff && !rsp_ready;
      stat.any_freed  = held_ff;
   end

   assign wr_addr = MEM_W'({tid_ff, count_ff[tid_ff][RD_W-1:0]});

   // hazard table
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NSLOTS; i++) hazard_ff[i] <= '0;
      end else if (cmd.table_op) begin
         unique case (kind_ff)
            KIND_RESERVE:   hazard_ff[HS_W'({tid_ff, slot_ff})] <= ptr_ff;
            KIND_CLEAR_ONE: hazard_ff[HS_W'({tid_ff, slot_ff})] <= '0;
            KIND_CLEAR_ALL: begin
               for (int s = 0; s < SLOTS_PER_THREAD; s++)
                  hazard_ff[HS_W'({tid_ff, SLOT_W'(s)})] <= '0;
            end
            default: ;
         endcase
      end
   end

   // retired list memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.retire_wr) retired_mem[wr_addr] <= ptr_ff;
      else if (cmd.scan_eval && prot)
         retired_mem[MEM_W'({tid_ff, wr_ff[RD_W-1:0]})] <= rdata_ff;
   end
   always_ff @(posedge clock) begin
      if (cmd.scan_rd) rdata_ff <= retired_mem[MEM_W'({tid_ff, rd_ff[RD_W-1:0]})];
   end

   // scan indexes
   always_comb begin
      rd_in = rd_ff;
      wr_in = wr_ff;
      if (cmd.scan_init) begin
         rd_in = '0;
         wr_in = '0;
      end else begin
         if (cmd.scan_rd) rd_in = rd_ff + 1'b1;
         if (cmd.scan_eval && prot) wr_in = wr_ff + 1'b1;
      end
   end
   always_ff @(posedge clock) begin
      rd_ff <= rd_in;
      wr_ff <= wr_in;
      if (cmd.retire_wr) n_ff <= count_ff[tid_ff] + 1'b1;
   end

   // per-thread counts
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < THREADS; t++) begin
            count_ff[t] <= '0;
            rcnt_ff[t] <= '0;
         end
      end else begin
         if (cmd.retire_wr) begin
            count_ff[tid_ff] <= count_ff[tid_ff] + 1'b1;
            rcnt_ff[tid_ff] <= stat.want_scan ? 8'd1 : rcnt_ff[tid_ff] + 8'd1;
         end
         if (cmd.scan_done) count_ff[tid_ff] <= wr_ff;
      end
   end

   // latest freed pointer held back until the next one or the end of the scan
   assign take_free = cmd.scan_eval && !prot;
   assign push_held = held_ff && (take_free || cmd.scan_done);

   always_ff @(posedge clock) begin
      if (reset) held_ff <= 1'b0;
      else if (cmd.scan_init || cmd.scan_done) held_ff <= 1'b0;
      else if (take_free) held_ff <= 1'b1;
   end
   always_ff @(posedge clock) begin
      if (take_free) held_ptr_ff <= rdata_ff;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.emit_ovf || push_held) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end
   always_ff @(posedge clock) begin
      if (cmd.emit_ovf) begin
         out_ptr_ff <= '0;
         out_ovf_ff <= 1'b1;
         out_last_ff <= 1'b1;
         out_tid_ff <= tid_ff;
      end else if (push_held) begin
         out_ptr_ff <= 48'(held_ptr_ff);
         out_ovf_ff <= 1'b0;
         out_last_ff <= cmd.scan_done;
         out_tid_ff <= tid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_freed_pointer = out_ptr_ff;
   assign rsp_owner_thread = out_tid_ff;
   assign rsp_overflow = out_ovf_ff;
   assign rsp_last_of_run = out_last_ff;
endmodule
`default_nettype wire

[src/hpr_controller.sv]
`default_nettype none
module hpr_controller (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire hpr_pkg::stat_type stat,
   output hpr_pkg::cmd_type cmd
);
   import hpr_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b00_0001,
      ST_EXEC  = 6'b00_0010,
      ST_READ  = 6'b00_0100,
      ST_EVAL  = 6'b00_1000,
      ST_WAIT  = 6'b01_0000,
      ST_DONE  = 6'b10_0000
   } state_type;

   state_type state_ff, state_in;

   // held output slot: busy when a result is not yet taken
   logic out_full;
   assign out_full = stat.out_busy;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !out_full;
            if (req_valid && !out_full) begin
               cmd.capture = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!stat.is_retire) begin
               cmd.table_op = 1'b1;
               state_in = ST_IDLE;
            end else if (stat.is_null) begin
               state_in = ST_IDLE;
            end else if (stat.list_full) begin
               cmd.emit_ovf = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cmd.retire_wr = 1'b1;
               if (stat.want_scan) begin
                  cmd.scan_init = 1'b1;
                  state_in = ST_READ;
               end else state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            if (stat.scan_empty) state_in = ST_DONE;
            else begin
               cmd.scan_rd = 1'b1;
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            // memory data lands in the read register
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            // a freed entry pushes the held result out, so the output must be free
            if (!(stat.entry_free && stat.any_freed && out_full)) begin
               cmd.scan_eval = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_DONE: begin
            // the held result goes out with the last marker
            if (!(stat.any_freed && out_full)) begin
               cmd.scan_done = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end
endmodule
`default_nettype wire

[src/hazard_pointer_reclaim_core.sv]
`default_nettype none
// hazard pointer reclamation core
// req channel: one transfer per request (reserve, clear one, clear all, retire)
// rsp channel: freed pointers from a scan in list order, or one overflow result;
//    last_of_run marks the final result of a request
// csr port: apb-style, register 0 collect_enable at 0x0, scan_frequency at 0x4
// table requests and a retire without scan execute in the cycle after the
//    transfer; a new request is taken only once the block is back in idle
// an overflow result is loaded into the output register from the execute state
// a scan walks the thread's retired list entry by entry through the read, wait
//    and evaluate states and the registered read of the list memory; no new
//    request is taken before the scan ends or while the receiver stalls
// each freed result is held back until the next freed entry is found or the
//    scan ends, so the last one carries last_of_run
// reset clears hazard slots, list counts and retire counters and restores
//    collect_enable=1, scan_frequency=30; list memory needs no clearing
// a stalled receiver stalls the scan and request intake
module hazard_pointer_reclaim_core (
   input  wire logic clock,
   input  wire logic reset,
   hpr_req_if.sink req,
   hpr_rsp_if.source rsp,
   input  wire logic csr_psel,
   input  wire logic csr_penable,
   input  wire logic csr_pwrite,
   input  wire logic [2:0] csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   import hpr_pkg::*;

   logic collect_enable_ff;
   logic [7:0] scan_frequency_ff;
   cmd_type cmd;
   stat_type stat;
   logic [1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx = csr_paddr[2] ? REG_SCAN_FREQUENCY : REG_COLLECT_ENABLE;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         collect_enable_ff <= 1'b1;
         scan_frequency_ff <= 8'd30;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (reg_idx)
            REG_COLLECT_ENABLE: collect_enable_ff <= csr_pwdata[0];
            REG_SCAN_FREQUENCY: scan_frequency_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end
   always_comb begin
      unique case (reg_idx)
         REG_SCAN_FREQUENCY: csr_prdata = {24'd0, scan_frequency_ff};
         default: csr_prdata = {31'd0, collect_enable_ff};
      endcase
   end

   hpr_controller u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
      .stat(stat), .cmd(cmd)
   );

   hpr_datapath u_dp (
      .clock(clock), .reset(reset),
      .req_kind(req.kind), .req_thread_id(req.thread_id),
      .req_slot_index(req.slot_index), .req_pointer_value(req.pointer_value),
      .collect_enable(collect_enable_ff), .scan_frequency(scan_frequency_ff),
      .cmd(cmd), .stat(stat),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .rsp_freed_pointer(rsp.freed_pointer), .rsp_owner_thread(rsp.owner_thread),
      .rsp_overflow(rsp.overflow), .rsp_last_of_run(rsp.last_of_run)
   );

   // an overflow result always closes its run
   a_ovf_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.overflow |-> rsp.last_of_run)
      else $error("overflow result without last marker");
   // no request taken while a result is stalled
   a_no_take: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |-> !req.ready)
      else $error("request accepted under stall");
endmodule
`default_nettype wire

[sim/tb.sv]
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import hpr_pkg::*;

   typedef struct packed {
      logic [47:0] freed_pointer;
      logic [2:0]  owner_thread;
      logic        overflow;
      logic        last_of_run;
   } release_type;

   typedef struct {
      kind_type    kind;
      logic [2:0]  thread_id;
      logic [1:0]  slot_index;
      logic [47:0] pointer_value;
      int          fixed_count;   // -1 means use the predictor
      release_type fixed_first;
   } stim_row_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [2:0] csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   hpr_req_if req ();
   hpr_rsp_if rsp ();

   hazard_pointer_reclaim_core i_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   // shadow of the block state
   logic [47:0] slot_table [NSLOTS];
   logic [47:0] retired_list [THREADS][RETIRE_DEPTH];
   int          list_len [THREADS];
   logic [7:0]  retire_tick [THREADS];
   logic        shadow_collect;
   logic [7:0]  shadow_frequency;

   release_type pending_releases [$];
   int  error_count = 0;
   int  release_count = 0;
   int  overflow_count = 0;
   int  scan_runs = 0;
   longint cycle_count = 0;
   bit  hold_off_long = 0;
   bit  no_idle = 0;
   int  last_made = 0;
   release_type last_first;

   function automatic bit is_guarded(logic [47:0] p);
      foreach (slot_table[i]) if (slot_table[i] == p) return 1;
      return 0;
   endfunction

   // append one expected result, remember what the last request produced
   function automatic void queue_release(release_type r);
      if (last_made == 0) last_first = r;
      last_made++;
      pending_releases.insert(pending_releases.size(), r);
   endfunction

   // predict the releases caused by one request, add them to the queue
   function automatic void predict_releases(kind_type k, logic [2:0] tid,
                                            logic [1:0] slot, logic [47:0] p);
      int kept;
      int freed;
      kept = 0;
      freed = 0;
      last_made = 0;
      case (k)
         KIND_RESERVE:   slot_table[tid*SLOTS_PER_THREAD + slot] = p;
         KIND_CLEAR_ONE: slot_table[tid*SLOTS_PER_THREAD + slot] = '0;
         KIND_CLEAR_ALL: for (int i = 0; i < SLOTS_PER_THREAD; i++)
                            slot_table[tid*SLOTS_PER_THREAD + i] = '0;
         default: begin
            if (p == 0) return;
            if (list_len[tid] >= RETIRE_DEPTH) begin
               queue_release('{48'd0, tid, 1'b1, 1'b1});
               return;
            end
            retired_list[tid][list_len[tid]] = p;
            list_len[tid]++;
            if (shadow_collect && retire_tick[tid] == shadow_frequency) begin
               retire_tick[tid] = 0;
               scan_runs++;
               for (int r_i = 0; r_i < list_len[tid]; r_i++) begin
                  if (is_guarded(retired_list[tid][r_i])) begin
                     retired_list[tid][kept] = retired_list[tid][r_i];
                     kept++;
                  end else begin
                     queue_release('{retired_list[tid][r_i], tid, 1'b0, 1'b0});
                     freed++;
                  end
               end
               list_len[tid] = kept;
               if (freed > 0)
                  pending_releases[pending_releases.size()-1].last_of_run = 1'b1;
               if (freed == 1) last_first.last_of_run = 1'b1;
            end
            retire_tick[tid] = retire_tick[tid] + 8'd1;
         end
      endcase
   endfunction

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver with random stalls
   initial begin
      int gap;
      rsp.ready = 0;
      forever begin
         @(negedge clock);
         if (hold_off_long) begin
            rsp.ready <= 0;
            for (int i = 0; i < 300; i++) @(negedge clock);
         end else if (!no_idle && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            rsp.ready <= 0;
            for (int i = 1; i < gap; i++) @(negedge clock);
         end else begin
            rsp.ready <= 1;
         end
      end
   end

   // result check
   always @(posedge clock) begin
      release_type got, want;
      if (!reset && rsp.valid && rsp.ready) begin
         got = '{rsp.freed_pointer, rsp.owner_thread, rsp.overflow, rsp.last_of_run};
         if (pending_releases.size() == 0) begin
            $error("unexpected result ptr=%h thread=%0d", got.freed_pointer,
                   got.owner_thread);
            error_count++;
         end else begin
            want = pending_releases.pop_front();
            if (got.freed_pointer !== want.freed_pointer) begin
               $error("freed_pointer exp %h got %h", want.freed_pointer, got.freed_pointer);
               error_count++;
            end
            if (got.owner_thread !== want.owner_thread) begin
               $error("owner_thread exp %0d got %0d", want.owner_thread, got.owner_thread);
               error_count++;
            end
            if (got.overflow !== want.overflow) begin
               $error("overflow exp %0d got %0d", want.overflow, got.overflow);
               error_count++;
            end
            if (got.last_of_run !== want.last_of_run) begin
               $error("last_of_run exp %0d got %0d", want.last_of_run, got.last_of_run);
               error_count++;
            end
            if (want.overflow) overflow_count++;
            else release_count++;
         end
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= {idx[0], 2'b00}; csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      if (idx == REG_COLLECT_ENABLE) shadow_collect = value[0];
      else shadow_frequency = value[7:0];
   endtask

   // wait until every result is out and the block takes requests again
   task automatic wait_drained();
      while (pending_releases.size() != 0 || !req.ready) @(negedge clock);
      for (int i = 0; i < 20; i++) @(negedge clock);
   endtask

   // offer one request and hold it until the transfer
   task automatic send_request(kind_type k, logic [2:0] tid, logic [1:0] slot,
                               logic [47:0] p);
      int gap;
      if (!no_idle && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 14);
         req.valid <= 0;
         for (int i = 0; i < gap; i++) @(negedge clock);
      end
      req.valid <= 1;
      req.kind <= k; req.thread_id <= tid; req.slot_index <= slot;
      req.pointer_value <= p;
      do @(posedge clock); while (!req.ready);
      predict_releases(k, tid, slot, p);
      @(negedge clock);
   endtask

   function automatic logic [47:0] random_pointer(int pool);
      if (pool > 0) return 48'(64'h1000 + $urandom_range(1, pool));
      return 48'({$urandom, $urandom});
   endfunction

   stim_row_type directed_rows [$];
   initial begin
      int pick;
      kind_type k;
      logic [2:0] tid;
      foreach (slot_table[i]) slot_table[i] = '0;
      foreach (list_len[i]) begin list_len[i] = 0; retire_tick[i] = 0; end
      shadow_collect = 1;
      shadow_frequency = 30;
      req.valid = 0; req.kind = KIND_RESERVE; req.thread_id = 0;
      req.slot_index = 0; req.pointer_value = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: first retire scans at frequency 0, extremes of each field
      csr_write(REG_SCAN_FREQUENCY, 0);
      directed_rows = '{
         '{KIND_RESERVE, 3'd7, 2'd3, 48'hFFFF_FFFF_FFFF, 0, '0},
         '{KIND_RETIRE,  3'd0, 2'd0, 48'h0, 0, '0},
         '{KIND_RETIRE,  3'd0, 2'd0, 48'h0000_0000_0001, 1,
           '{48'h1, 3'd0, 1'b0, 1'b1}},
         '{KIND_RETIRE,  3'd7, 2'd0, 48'hFFFF_FFFF_FFFF, 0, '0},
         '{KIND_RESERVE, 3'd0, 2'd0, 48'hAAAA_5555_AAAA, 0, '0},
         '{KIND_RESERVE, 3'd0, 2'd0, 48'h0, -1, '0},
         '{KIND_CLEAR_ONE, 3'd7, 2'd3, 48'h0, -1, '0},
         '{KIND_CLEAR_ALL, 3'd0, 2'd0, 48'h0, -1, '0},
         '{KIND_RETIRE,  3'd7, 2'd1, 48'h5555_AAAA_5555, -1, '0},
         '{KIND_RETIRE,  3'd3, 2'd2, 48'h1234_5678_9ABC, -1, '0}
      };
      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].kind, directed_rows[i].thread_id,
                      directed_rows[i].slot_index, directed_rows[i].pointer_value);
         if (directed_rows[i].fixed_count >= 0) begin
            if (last_made != directed_rows[i].fixed_count) begin
               $error("row %0d result count exp %0d got %0d", i,
                      directed_rows[i].fixed_count, last_made);
               error_count++;
            end else if (directed_rows[i].fixed_count == 1 &&
                         last_first !== directed_rows[i].fixed_first) begin
               $error("row %0d typed result mismatch", i);
               error_count++;
            end
         end
      end
      req.valid <= 0;
      wait_drained();

      // overflow: collection off, fill thread 5 and go past the end
      csr_write(REG_COLLECT_ENABLE, 0);
      for (int i = 0; i < RETIRE_DEPTH + 2; i++) begin
         send_request(KIND_RETIRE, 3'd5, 2'd0, 48'(64'h2000 + i));
         if (i >= RETIRE_DEPTH && (last_made != 1 ||
             last_first !== release_type'{48'd0, 3'd5, 1'b1, 1'b1})) begin
            $error("overflow result exp on retire %0d", i);
            error_count++;
         end
      end
      req.valid <= 0;
      wait_drained();

      // long receiver hold-off while scans pile up
      csr_write(REG_COLLECT_ENABLE, 1);
      csr_write(REG_SCAN_FREQUENCY, 255);
      csr_write(REG_SCAN_FREQUENCY, 2);
      fork
         begin
            hold_off_long = 1;
            for (int i = 0; i < 250; i++) @(negedge clock);
            hold_off_long = 0;
         end
         begin
            for (int i = 0; i < 12; i++)
               send_request(KIND_RETIRE, 3'($urandom_range(0, 7)), 2'd0,
                            random_pointer(6));
            req.valid <= 0;
         end
      join
      wait_drained();

      // random: mostly protect/retire pools of small pointers, some full-width noise
      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) csr_write(REG_SCAN_FREQUENCY, $urandom_range(0, 3));
         if (phase == 2) begin
            csr_write(REG_SCAN_FREQUENCY, 1);
            no_idle = 1;
         end
         for (int i = 0; i < 18; i++) begin
            pick = $urandom_range(0, 9);
            k = pick < 3 ? KIND_RESERVE : pick < 4 ? KIND_CLEAR_ONE :
                pick < 5 ? KIND_CLEAR_ALL : KIND_RETIRE;
            tid = 3'($urandom_range(0, 7));
            send_request(k, tid, 2'($urandom_range(0, 3)),
                         $urandom_range(0, 7) == 0 ? random_pointer(0) :
                         random_pointer(12));
         end
         req.valid <= 0;
         wait_drained();
      end

      $display("covered %0d freed results, %0d overflow results, %0d scans",
               release_count, overflow_count, scan_runs);
      if (error_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule
`default_nettype wire

[files.f]
src/hpr_pkg.sv
src/hpr_if.sv
src/hpr_datapath.sv
src/hpr_controller.sv
src/hazard_pointer_reclaim_core.sv
sim/tb.sv
